/* hdl/gtfr_pkg.sv */
package gtfr_pkg;

  localparam int GLYPH_W = 3;
  localparam int GLYPH_H = 5;
  localparam int GLYPH_ADVANCE = 4;
  // Wide enough for any byte address sum at the largest buffer size.
  localparam int ADDR_CALC_W = 14;

  localparam logic [2:0] MODE_CLEAR   = 3'd0;
  localparam logic [2:0] MODE_ORIGIN  = 3'd1;
  localparam logic [2:0] MODE_DRAW    = 3'd2;
  localparam logic [2:0] MODE_PRESENT = 3'd3;
  localparam logic [2:0] MODE_READ    = 3'd4;

  typedef struct packed {
    logic [2:0] mode;
    logic [7:0] char_code;
    logic [6:0] pos_x;
    logic [5:0] pos_y;
    logic [9:0] byte_index;
  } in_item_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       frame_changed;
    logic       char_dropped;
  } out_item_t;

  typedef struct packed {
    logic accept;
    logic init_step;
    logic clear_step;
    logic pres_step;
    logic draw_rd;
    logic draw_wr;
    logic read_rd;
    logic read_cap;
    logic fin_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic [2:0] in_mode;
    logic       in_read_ok;
    logic       line_done;
    logic       sweep_last;
    logic       draw_last;
    logic       out_free;
  } ctrl_stat_t;

  // Glyph rows packed top row first; each row is 3 bits, leftmost pixel in the MSB.
  function automatic logic [14:0] glyph_rows(input logic [7:0] code_in);
    logic [7:0]  code;
    logic [14:0] g;
    code = code_in;
    if (code >= 8'h61 && code <= 8'h7a) begin
      code = code - 8'd32;
    end
    case (code)
      8'h25: g = {3'd5, 3'd1, 3'd2, 3'd4, 3'd5};
      8'h2b: g = {3'd0, 3'd2, 3'd7, 3'd2, 3'd0};
      8'h2d: g = {3'd0, 3'd0, 3'd7, 3'd0, 3'd0};
      8'h2e: g = {3'd0, 3'd0, 3'd0, 3'd0, 3'd2};
      8'h30: g = {3'd7, 3'd5, 3'd5, 3'd5, 3'd7};
      8'h31: g = {3'd2, 3'd6, 3'd2, 3'd2, 3'd7};
      8'h32: g = {3'd7, 3'd1, 3'd7, 3'd4, 3'd7};
      8'h33: g = {3'd7, 3'd1, 3'd7, 3'd1, 3'd7};
      8'h34: g = {3'd5, 3'd5, 3'd7, 3'd1, 3'd1};
      8'h35: g = {3'd7, 3'd4, 3'd7, 3'd1, 3'd7};
      8'h36: g = {3'd7, 3'd4, 3'd7, 3'd5, 3'd7};
      8'h37: g = {3'd7, 3'd1, 3'd2, 3'd4, 3'd4};
      8'h38: g = {3'd7, 3'd5, 3'd7, 3'd5, 3'd7};
      8'h39: g = {3'd7, 3'd5, 3'd7, 3'd1, 3'd7};
      8'h41: g = {3'd2, 3'd5, 3'd7, 3'd5, 3'd5};
      8'h42: g = {3'd6, 3'd5, 3'd6, 3'd5, 3'd6};
      8'h43: g = {3'd3, 3'd4, 3'd4, 3'd4, 3'd3};
      8'h44: g = {3'd6, 3'd5, 3'd5, 3'd5, 3'd6};
      8'h45: g = {3'd7, 3'd4, 3'd6, 3'd4, 3'd7};
      8'h46: g = {3'd7, 3'd4, 3'd6, 3'd4, 3'd4};
      8'h47: g = {3'd3, 3'd4, 3'd5, 3'd5, 3'd3};
      8'h48: g = {3'd5, 3'd5, 3'd7, 3'd5, 3'd5};
      8'h49: g = {3'd7, 3'd2, 3'd2, 3'd2, 3'd7};
      8'h4a: g = {3'd7, 3'd1, 3'd1, 3'd5, 3'd7};
      8'h4b: g = {3'd5, 3'd5, 3'd6, 3'd5, 3'd5};
      8'h4c: g = {3'd4, 3'd4, 3'd4, 3'd4, 3'd7};
      8'h4d: g = {3'd5, 3'd7, 3'd5, 3'd5, 3'd5};
      8'h4e: g = {3'd5, 3'd7, 3'd7, 3'd7, 3'd5};
      8'h4f: g = {3'd7, 3'd5, 3'd5, 3'd5, 3'd7};
      8'h50: g = {3'd6, 3'd5, 3'd6, 3'd4, 3'd4};
      8'h51: g = {3'd7, 3'd5, 3'd5, 3'd7, 3'd1};
      8'h52: g = {3'd6, 3'd5, 3'd6, 3'd5, 3'd5};
      8'h53: g = {3'd7, 3'd4, 3'd7, 3'd1, 3'd7};
      8'h54: g = {3'd7, 3'd2, 3'd2, 3'd2, 3'd2};
      8'h55: g = {3'd5, 3'd5, 3'd5, 3'd5, 3'd7};
      8'h57: g = {3'd5, 3'd5, 3'd7, 3'd7, 3'd5};
      8'h58: g = {3'd5, 3'd5, 3'd2, 3'd5, 3'd5};
      8'h59: g = {3'd5, 3'd5, 3'd2, 3'd2, 3'd2};
      default: g = '0;
    endcase
    return g;
  endfunction

endpackage

/* hdl/gtfr_ram.sv */
module gtfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hdl/gtfr_ctrl.sv */
module gtfr_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  gtfr_pkg::ctrl_stat_t stat,
  output gtfr_pkg::ctrl_cmd_t  cmd
);
  import gtfr_pkg::*;

  typedef enum logic [9:0] {
    S_INIT  = 10'b0000000001,
    S_IDLE  = 10'b0000000010,
    S_CLEAR = 10'b0000000100,
    S_PRES  = 10'b0000001000,
    S_PTAIL = 10'b0000010000,
    S_DRD   = 10'b0000100000,
    S_DWR   = 10'b0001000000,
    S_RRD   = 10'b0010000000,
    S_RCAP  = 10'b0100000000,
    S_FIN   = 10'b1000000000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.accept     = in_ready && in_valid;
    cmd.init_step  = (state == S_INIT);
    cmd.clear_step = (state == S_CLEAR);
    cmd.pres_step  = (state == S_PRES);
    cmd.draw_rd    = (state == S_DRD);
    cmd.draw_wr    = (state == S_DWR);
    cmd.read_rd    = (state == S_RRD);
    cmd.read_cap   = (state == S_RCAP);
    cmd.fin_load   = (state == S_FIN) && stat.out_free;
  end

  always_comb begin
    state_next = state;
    case (state)
      S_INIT: begin
        if (stat.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          case (stat.in_mode)
            MODE_CLEAR:   state_next = S_CLEAR;
            MODE_DRAW:    state_next = stat.line_done ? S_FIN : S_DRD;
            MODE_PRESENT: state_next = S_PRES;
            MODE_READ:    state_next = stat.in_read_ok ? S_RRD : S_FIN;
            default:      state_next = S_FIN;
          endcase
        end
      end
      S_CLEAR: begin
        if (stat.sweep_last) state_next = S_FIN;
      end
      S_PRES: begin
        if (stat.sweep_last) state_next = S_PTAIL;
      end
      S_PTAIL: state_next = S_FIN;
      S_DRD:   state_next = S_DWR;
      S_DWR: begin
        state_next = stat.draw_last ? S_FIN : S_DRD;
      end
      S_RRD:  state_next = S_RCAP;
      S_RCAP: state_next = S_FIN;
      S_FIN: begin
        if (stat.out_free) state_next = S_IDLE;
      end
      default: state_next = S_INIT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

`ifndef NO_ASSERTIONS
  a_onehot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("controller state not one-hot");
  a_one_item: assert property (@(posedge clk) disable iff (rst) cmd.accept |=> !in_ready)
    else $error("second item taken while one is in work");
  a_rmw_pair: assert property (@(posedge clk) disable iff (rst)
    cmd.draw_wr |-> $past(cmd.draw_rd))
    else $error("glyph write without a preceding read");
  a_tail: assert property (@(posedge clk) disable iff (rst)
    (state == S_PTAIL) |-> $past(cmd.pres_step && stat.sweep_last))
    else $error("present tail entered before the sweep ended");
`endif

endmodule

/* hdl/gtfr_dp.sv */
module gtfr_dp #(
  parameter int FB_WIDTH = 128,
  parameter int FB_HEIGHT = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  gtfr_pkg::in_item_t  in_item,
  input  logic                out_ready,
  output logic                out_valid,
  output gtfr_pkg::out_item_t out_item,
  input  gtfr_pkg::ctrl_cmd_t  cmd,
  output gtfr_pkg::ctrl_stat_t stat
);
  import gtfr_pkg::*;

  localparam int FB_PAGES = (FB_HEIGHT + 7) / 8;
  localparam int FB_BYTES = FB_WIDTH * FB_PAGES;
  localparam int AW = $clog2(FB_BYTES);

  logic [2:0]    mode;
  logic [AW-1:0] rd_index;
  logic [7:0]    cursor_col;
  logic [5:0]    cursor_row;
  logic          line_done;
  logic          shown_valid;
  logic          dropped;
  logic          diff;
  logic [7:0]    res_data;
  logic [AW-1:0] cnt;
  logic          p_valid;
  logic [AW-1:0] p_addr;
  logic [7:0]    dx;
  logic [5:0]    dy;
  logic [14:0]   gl;
  logic [1:0]    dcol;
  logic          dpg;
  logic [AW-1:0] daddr;
  logic [7:0]    dbits;
  logic          dwen;

  logic [8:0]             nxt_col;
  logic [8:0]             x9;
  logic [4:0]             colmask;
  logic [12:0]            shifted;
  logic [3:0]             page;
  logic [ADDR_CALC_W-1:0] addr_calc;
  logic [7:0]             bits_calc;
  logic                   wen_calc;

  logic          f_we, s_we;
  logic [AW-1:0] f_waddr, f_raddr, s_waddr;
  logic [7:0]    f_wdata, s_wdata, f_rdata, s_rdata;

  assign nxt_col = {1'b0, cursor_col} + 9'(GLYPH_ADVANCE);

  // Address and bits for one glyph column within one of the two pages it may span.
  always_comb begin
    x9 = 9'(dx) + 9'(dcol);
    for (int r = 0; r < GLYPH_H; r++) begin
      colmask[r] = gl[14 - 3 * r - int'(dcol)] && ((8'(dy) + 8'(r)) < 8'(FB_HEIGHT));
    end
    shifted   = 13'(colmask) << dy[2:0];
    bits_calc = dpg ? {3'b000, shifted[12:8]} : shifted[7:0];
    page      = 4'(dy[5:3]) + 4'(dpg);
    addr_calc = ADDR_CALC_W'(x9) + ADDR_CALC_W'(page) * ADDR_CALC_W'(FB_WIDTH);
    wen_calc  = (bits_calc != 8'd0) && (x9 < 9'(FB_WIDTH));
  end

  always_comb begin
    f_we    = cmd.init_step || cmd.clear_step || (cmd.draw_wr && dwen);
    f_waddr = cmd.draw_wr ? daddr : cnt;
    f_wdata = cmd.draw_wr ? (f_rdata | dbits) : 8'd0;
    if (cmd.draw_rd) begin
      f_raddr = addr_calc[AW-1:0];
    end else if (cmd.read_rd) begin
      f_raddr = rd_index;
    end else begin
      f_raddr = cnt;
    end
    s_we    = cmd.init_step || p_valid;
    s_waddr = p_valid ? p_addr : cnt;
    s_wdata = p_valid ? f_rdata : 8'd0;
  end

  gtfr_ram #(.WIDTH(8), .DEPTH(FB_BYTES)) u_frame (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (f_wdata),
    .raddr (f_raddr),
    .rdata (f_rdata)
  );

  gtfr_ram #(.WIDTH(8), .DEPTH(FB_BYTES)) u_shown (
    .clk   (clk),
    .we    (s_we),
    .waddr (s_waddr),
    .wdata (s_wdata),
    .raddr (cnt),
    .rdata (s_rdata)
  );

  always_comb begin
    stat.in_mode    = in_item.mode;
    stat.in_read_ok = ADDR_CALC_W'(in_item.byte_index) < ADDR_CALC_W'(FB_BYTES);
    stat.line_done  = line_done;
    stat.sweep_last = (cnt == AW'(FB_BYTES - 1));
    stat.draw_last  = (dcol == 2'd2) && dpg;
    stat.out_free   = !out_valid || out_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col  <= '0;
      cursor_row  <= '0;
      line_done   <= 1'b0;
      shown_valid <= 1'b0;
      cnt         <= '0;
      p_valid     <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      p_valid <= cmd.pres_step;
      if (cmd.init_step || cmd.clear_step || cmd.pres_step) begin
        cnt <= cnt + AW'(1);
      end
      if (cmd.accept) begin
        cnt <= '0;
        case (in_item.mode)
          MODE_ORIGIN: begin
            cursor_col <= 8'(in_item.pos_x);
            cursor_row <= in_item.pos_y;
            line_done  <= 1'b0;
          end
          MODE_DRAW: begin
            if (!line_done) begin
              if (nxt_col > 9'(FB_WIDTH - GLYPH_W)) line_done <= 1'b1;
              cursor_col <= nxt_col[8] ? 8'hff : nxt_col[7:0];
            end
          end
          MODE_PRESENT: shown_valid <= 1'b1;
          default: ;
        endcase
      end
      if (cmd.fin_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    p_addr <= cnt;
    if (cmd.accept) begin
      mode     <= in_item.mode;
      rd_index <= AW'(ADDR_CALC_W'(in_item.byte_index));
      dropped  <= (in_item.mode == MODE_DRAW) && line_done;
      diff     <= !shown_valid;
      dx       <= cursor_col;
      dy       <= cursor_row;
      gl       <= glyph_rows(in_item.char_code);
      dcol     <= '0;
      dpg      <= 1'b0;
      res_data <= '0;
    end
    if (p_valid && (f_rdata != s_rdata)) begin
      diff <= 1'b1;
    end
    if (cmd.draw_rd) begin
      daddr <= addr_calc[AW-1:0];
      dbits <= bits_calc;
      dwen  <= wen_calc;
    end
    if (cmd.draw_wr) begin
      dpg <= !dpg;
      if (dpg) dcol <= dcol + 2'd1;
    end
    if (cmd.read_cap) begin
      res_data <= f_rdata;
    end
    if (cmd.fin_load) begin
      out_item.read_data     <= (mode == MODE_READ) ? res_data : 8'd0;
      out_item.frame_changed <= (mode == MODE_PRESENT) && diff;
      out_item.char_dropped  <= (mode == MODE_DRAW) && dropped;
    end
  end

`ifndef NO_ASSERTIONS
  a_pres_pipe: assert property (@(posedge clk) disable iff (rst)
    p_valid |-> $past(cmd.pres_step) && (p_addr == $past(cnt)))
    else $error("present write-back out of step with the sweep");
`endif

endmodule

/* hdl/glyph_text_framebuffer_renderer.sv */
// Renders 3x5 font text into a page-packed monochrome framebuffer (one byte holds eight
// vertical pixels) and keeps a copy of the last presented frame. One item is in work at a
// time, and a finished result waits in an output register while the next item is taken.
// Clear and present sweep the memories one byte per cycle, and a draw does six
// read-modify-writes (three glyph columns, each on two pages); read byte reads and then
// captures, while set origin, unused modes, a dropped character and an out-of-range read
// go straight to the result. A result held by the receiver stalls the block in its
// final state. After reset a clearing pass zeroes both memories before the first item
// is accepted.
module glyph_text_framebuffer_renderer #(
  parameter int FB_WIDTH = 128,
  parameter int FB_HEIGHT = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  gtfr_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output gtfr_pkg::out_item_t out_item
);
  import gtfr_pkg::*;

  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  gtfr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gtfr_dp #(.FB_WIDTH(FB_WIDTH), .FB_HEIGHT(FB_HEIGHT)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_item   (in_item),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

/* tb/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import gtfr_pkg::*;

  localparam int FB_WIDTH = 128;
  localparam int FB_HEIGHT = 64;
  localparam int FB_BYTES = FB_WIDTH * ((FB_HEIGHT + 7) / 8);
  localparam int RANDOM_ITEMS = 1300;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;

  glyph_text_framebuffer_renderer #(.FB_WIDTH(FB_WIDTH), .FB_HEIGHT(FB_HEIGHT)) dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Shadow of the renderer state.
  logic [7:0] frame_mem [FB_BYTES];
  logic [7:0] shown_mem [FB_BYTES];
  logic shown_ok;
  logic [7:0] col;
  logic [5:0] row;
  logic line_end;

  in_item_t pending_items[$];
  out_item_t expected_results[$];
  int errors = 0;
  bit stimulus_done = 1'b0;
  bit hold_off = 1'b0;

  function automatic logic [14:0] font_rows(input logic [7:0] ch);
    logic [7:0] c;
    c = ch;
    if (c >= "a" && c <= "z") c = c - 8'd32;
    case (c)
      "%": return {3'd5, 3'd1, 3'd2, 3'd4, 3'd5};
      "+": return {3'd0, 3'd2, 3'd7, 3'd2, 3'd0};
      "-": return {3'd0, 3'd0, 3'd7, 3'd0, 3'd0};
      ".": return {3'd0, 3'd0, 3'd0, 3'd0, 3'd2};
      "0": return {3'd7, 3'd5, 3'd5, 3'd5, 3'd7};
      "1": return {3'd2, 3'd6, 3'd2, 3'd2, 3'd7};
      "2": return {3'd7, 3'd1, 3'd7, 3'd4, 3'd7};
      "3": return {3'd7, 3'd1, 3'd7, 3'd1, 3'd7};
      "4": return {3'd5, 3'd5, 3'd7, 3'd1, 3'd1};
      "5": return {3'd7, 3'd4, 3'd7, 3'd1, 3'd7};
      "6": return {3'd7, 3'd4, 3'd7, 3'd5, 3'd7};
      "7": return {3'd7, 3'd1, 3'd2, 3'd4, 3'd4};
      "8": return {3'd7, 3'd5, 3'd7, 3'd5, 3'd7};
      "9": return {3'd7, 3'd5, 3'd7, 3'd1, 3'd7};
      "A": return {3'd2, 3'd5, 3'd7, 3'd5, 3'd5};
      "B": return {3'd6, 3'd5, 3'd6, 3'd5, 3'd6};
      "C": return {3'd3, 3'd4, 3'd4, 3'd4, 3'd3};
      "D": return {3'd6, 3'd5, 3'd5, 3'd5, 3'd6};
      "E": return {3'd7, 3'd4, 3'd6, 3'd4, 3'd7};
      "F": return {3'd7, 3'd4, 3'd6, 3'd4, 3'd4};
      "G": return {3'd3, 3'd4, 3'd5, 3'd5, 3'd3};
      "H": return {3'd5, 3'd5, 3'd7, 3'd5, 3'd5};
      "I": return {3'd7, 3'd2, 3'd2, 3'd2, 3'd7};
      "J": return {3'd7, 3'd1, 3'd1, 3'd5, 3'd7};
      "K": return {3'd5, 3'd5, 3'd6, 3'd5, 3'd5};
      "L": return {3'd4, 3'd4, 3'd4, 3'd4, 3'd7};
      "M": return {3'd5, 3'd7, 3'd5, 3'd5, 3'd5};
      "N": return {3'd5, 3'd7, 3'd7, 3'd7, 3'd5};
      "O": return {3'd7, 3'd5, 3'd5, 3'd5, 3'd7};
      "P": return {3'd6, 3'd5, 3'd6, 3'd4, 3'd4};
      "Q": return {3'd7, 3'd5, 3'd5, 3'd7, 3'd1};
      "R": return {3'd6, 3'd5, 3'd6, 3'd5, 3'd5};
      "S": return {3'd7, 3'd4, 3'd7, 3'd1, 3'd7};
      "T": return {3'd7, 3'd2, 3'd2, 3'd2, 3'd2};
      "U": return {3'd5, 3'd5, 3'd5, 3'd5, 3'd7};
      "W": return {3'd5, 3'd5, 3'd7, 3'd7, 3'd5};
      "X": return {3'd5, 3'd5, 3'd2, 3'd5, 3'd5};
      "Y": return {3'd5, 3'd5, 3'd2, 3'd2, 3'd2};
      default: return '0;
    endcase
  endfunction

  function automatic out_item_t render_item(input in_item_t it);
    out_item_t r;
    logic [14:0] g;
    int x, y, nxt;
    bit diff;
    r = '0;
    case (it.mode)
      MODE_CLEAR: begin
        foreach (frame_mem[i]) frame_mem[i] = '0;
      end
      MODE_ORIGIN: begin
        col = 8'(it.pos_x);
        row = it.pos_y;
        line_end = 1'b0;
      end
      MODE_DRAW: begin
        if (line_end) begin
          r.char_dropped = 1'b1;
        end else begin
          g = font_rows(it.char_code);
          for (int rr = 0; rr < GLYPH_H; rr++) begin
            for (int cc = 0; cc < GLYPH_W; cc++) begin
              x = col + cc;
              y = row + rr;
              if (g[14 - 3 * rr - cc] && x < FB_WIDTH && y < FB_HEIGHT) begin
                frame_mem[x + (y / 8) * FB_WIDTH][y % 8] = 1'b1;
              end
            end
          end
          nxt = col + GLYPH_ADVANCE;
          if (nxt > FB_WIDTH - GLYPH_W) line_end = 1'b1;
          col = (nxt > 255) ? 8'd255 : 8'(nxt);
        end
      end
      MODE_PRESENT: begin
        diff = 1'b0;
        foreach (frame_mem[i]) if (frame_mem[i] != shown_mem[i]) diff = 1'b1;
        if (!shown_ok || diff) begin
          shown_mem = frame_mem;
          shown_ok = 1'b1;
          r.frame_changed = 1'b1;
        end
      end
      MODE_READ: begin
        if (it.byte_index < FB_BYTES) r.read_data = frame_mem[it.byte_index];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic in_item_t make_item(input logic [2:0] m, input logic [7:0] ch = '0,
                                         input logic [6:0] px = '0, input logic [5:0] py = '0,
                                         input logic [9:0] bi = '0);
    in_item_t it;
    it.mode = m;
    it.char_code = ch;
    it.pos_x = px;
    it.pos_y = py;
    it.byte_index = bi;
    return it;
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    int pick;
    it = in_item_t'({$urandom, $urandom});
    pick = $urandom_range(0, 99);
    if (pick < 55) it.mode = MODE_DRAW;
    else if (pick < 65) it.mode = MODE_ORIGIN;
    else if (pick < 88) it.mode = MODE_READ;
    else if (pick < 94) it.mode = MODE_PRESENT;
    else if (pick < 96) it.mode = MODE_CLEAR;
    else it.mode = 3'($urandom_range(5, 7));
    // Mostly printable text so that real glyphs land in the buffer.
    if (it.mode == MODE_DRAW && $urandom_range(0, 3) != 0) it.char_code = 8'($urandom_range(32, 122));
    if (it.mode == MODE_READ && $urandom_range(0, 9) == 0) it.byte_index = 10'($urandom_range(0, 1023));
    return it;
  endfunction

  function automatic int gap_len();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40) :
           ($urandom_range(0, 1) == 0 ? 0 : $urandom_range(0, 3));
  endfunction

  initial begin
    foreach (frame_mem[i]) frame_mem[i] = '0;
    foreach (shown_mem[i]) shown_mem[i] = '0;
    shown_ok = 1'b0;
    col = '0;
    row = '0;
    line_end = 1'b0;

    // Directed part: present before anything, glyph folding, clipping, line end.
    pending_items.push_back(make_item(MODE_PRESENT));
    pending_items.push_back(make_item(MODE_PRESENT));
    pending_items.push_back(make_item(MODE_DRAW, "a"));
    pending_items.push_back(make_item(MODE_DRAW, "V"));
    pending_items.push_back(make_item(MODE_DRAW, 8'hff));
    pending_items.push_back(make_item(MODE_DRAW, 8'h00));
    pending_items.push_back(make_item(MODE_READ, 0, 0, 0, 10'd0));
    pending_items.push_back(make_item(MODE_READ, 0, 0, 0, 10'd1023));
    pending_items.push_back(make_item(MODE_ORIGIN, 0, 7'd127, 6'd63));
    pending_items.push_back(make_item(MODE_DRAW, "8"));
    pending_items.push_back(make_item(MODE_DRAW, "8"));
    pending_items.push_back(make_item(MODE_ORIGIN, 0, 7'd124, 6'd61));
    pending_items.push_back(make_item(MODE_DRAW, "%"));
    pending_items.push_back(make_item(MODE_READ, 0, 0, 0, 10'd1023));
    pending_items.push_back(make_item(MODE_ORIGIN, 0, 7'd120, 6'd3));
    pending_items.push_back(make_item(MODE_DRAW, "M"));
    pending_items.push_back(make_item(MODE_DRAW, "z"));
    pending_items.push_back(make_item(MODE_READ, 0, 0, 0, 10'd248));
    pending_items.push_back(make_item(MODE_PRESENT));
    pending_items.push_back(make_item(MODE_PRESENT));
    pending_items.push_back(make_item(MODE_CLEAR));
    pending_items.push_back(make_item(MODE_READ, 0, 0, 0, 10'd248));
    pending_items.push_back(make_item(MODE_PRESENT));
    pending_items.push_back(make_item(3'd7, 8'hff, 7'h7f, 6'h3f, 10'h3ff));
    pending_items.push_back(make_item(3'd5));
    for (int i = 0; i < RANDOM_ITEMS; i++) pending_items.push_back(random_item());
    stimulus_done = 1'b1;
  end

  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
  end

  // Sender: gaps between items, payload held until accepted.
  int send_gap = 0;
  bit in_taken = 1'b0;
  always @(negedge clk) begin
    if (!rst) begin
      if (in_valid && !in_taken) begin
      end else if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_item <= pending_items.pop_front();
        in_valid <= 1'b1;
        send_gap <= gap_len();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off partway through.
  int recv_gap = 0;
  int accepted = 0;
  int hold_cycles = 0;
  always @(negedge clk) begin
    if (hold_off) begin
      out_ready <= 1'b0;
    end else if (recv_gap > 0) begin
      recv_gap <= recv_gap - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 3) == 0) recv_gap <= gap_len();
    end
  end

  always @(posedge clk) begin
    if (!hold_off && accepted == 300 && hold_cycles == 0) begin
      hold_off <= 1'b1;
      hold_cycles <= 1;
    end else if (hold_off) begin
      if (hold_cycles >= 400) hold_off <= 1'b0;
      hold_cycles <= hold_cycles + 1;
    end
  end

  always @(posedge clk) begin
    out_item_t exp_r;
    if (!rst) begin
      in_taken <= in_valid && in_ready;
      if (in_valid && in_ready) begin
        expected_results.push_back(render_item(in_item));
        accepted <= accepted + 1;
      end
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result %p", $realtime, out_item);
        end else begin
          exp_r = expected_results.pop_front();
          if (out_item.read_data !== exp_r.read_data) begin
            errors++;
            $display("%0t: read_data expected %0h actual %0h", $realtime,
                     exp_r.read_data, out_item.read_data);
          end
          if (out_item.frame_changed !== exp_r.frame_changed) begin
            errors++;
            $display("%0t: frame_changed expected %0b actual %0b", $realtime,
                     exp_r.frame_changed, out_item.frame_changed);
          end
          if (out_item.char_dropped !== exp_r.char_dropped) begin
            errors++;
            $display("%0t: char_dropped expected %0b actual %0b", $realtime,
                     exp_r.char_dropped, out_item.char_dropped);
          end
        end
      end
    end
  end

  initial begin
    wait (stimulus_done);
    wait (!rst);
    while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (3 * FB_BYTES) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("tb_top NOT OK");
    $finish;
  end

endmodule
